// ----- rtl/core/pcle_pkg.sv -----
`timescale 1ns / 1ps

package pcle_pkg;

	localparam int SUM_W  = 13;
	localparam int POS_W  = 11;
	localparam int LUMA_W = 15;
	localparam int CHR_W  = 6;
	localparam int ROM_W  = 9;
	localparam int SMP_W  = 16;

	localparam logic [63:0] CARRIER_NUM  = 64'd17734475;
	localparam logic [63:0] CLOCK_DEN    = 64'd53333332;
	localparam logic [63:0] BURST_ORIGIN = 64'd70;
	localparam logic [63:0] U_GAIN       = 64'd111820288;
	localparam logic [63:0] V_GAIN       = 64'd157382912;
	localparam logic [63:0] Q30_ONE      = 64'h4000_0000;
	localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
	localparam logic [63:0] MICRO        = 64'd1000000;
	localparam logic [63:0] ROUND_DEN    = Q30_ONE * MICRO;
	localparam logic [63:0] ROUND_HALF   = (Q30_ONE / 64'd2) * MICRO;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	localparam int BLANK_LEVEL  = 23;
	localparam int FULL_LEVEL   = 54;
	localparam int CHROMA_LEVEL = 27;
	localparam int CHROMA_ZERO  = 8;

	typedef enum logic [1:0] {
		CFG_SAMPLES_MODE = 2'd0,
		CFG_HSTART       = 2'd1,
		CFG_CHROMA_MIX   = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SPP_ONE  = 2'd0,
		SPP_TWO  = 2'd1,
		SPP_FOUR = 2'd2
	} spp_mode_t;

	typedef struct packed {
		logic [1:0] samples_mode;
		logic [9:0] horizontal_start;
		logic       chroma_mix;
	} cfg_t;

	typedef struct packed {
		logic                     valid;
		logic                     last;
		logic [LUMA_W-1:0]        ye;
		logic [LUMA_W-1:0]        yo;
		logic signed [CHR_W-1:0]  ul;
		logic signed [CHR_W-1:0]  vl;
	} smp_t;

	function automatic logic [LUMA_W-1:0] luma_level(input int code);
		int v;
		v = BLANK_LEVEL * 256 + (code * FULL_LEVEL * 256 + 7) / 15;
		return LUMA_W'(v);
	endfunction

	function automatic logic signed [CHR_W-1:0] chroma_level(input int code);
		int n;
		int v;
		n = (code - CHROMA_ZERO) * CHROMA_LEVEL;
		if (n < 0)
			v = -((-n * 2 + 7) / 14);
		else
			v = (n * 2 + 7) / 14;
		return CHR_W'(v);
	endfunction

	// quarter-wave fold, Taylor series to x^11 in unsigned Q30
	function automatic logic signed [ROM_W-1:0] rom_entry(input logic [31:0] turn,
		input logic [63:0] gain);
		logic [63:0] r;
		logic [63:0] a;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] mag;
		logic signed [ROM_W-1:0] v;
		r = {34'd0, turn[29:0]};
		a = turn[30] ? (Q30_ONE - r) : r;
		x = (a * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t = Q30_ONE;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
		t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
		s = (x * t) >> 30;
		if (s > Q30_ONE)
			s = Q30_ONE;
		mag = (s * gain + ROUND_HALF) / ROUND_DEN;
		v = ROM_W'(mag);
		if (turn[31])
			v = -v;
		return v;
	endfunction

endpackage

// ----- rtl/core/pcle_seq.sv -----
`timescale 1ns / 1ps

module pcle_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pcle_pkg::cfg_t             cfg,
	input  logic                       start,
	output logic                       busy,
	input  logic [9:0]                 pixel_column,
	input  logic [3:0]                 luma_even,
	input  logic [3:0]                 luma_odd,
	input  logic [3:0]                 u_even,
	input  logic [3:0]                 u_odd,
	input  logic [3:0]                 v_even,
	input  logic [3:0]                 v_odd,
	output pcle_pkg::smp_t             smp_s1,
	output logic [pcle_pkg::SUM_W-1:0] sum_s1
);
	import pcle_pkg::*;

	logic [LUMA_W-1:0]       luma_tab [16];
	logic signed [CHR_W-1:0] chroma_tab [16];

	for (genvar g = 0; g < 16; g++) begin : g_tab
		localparam logic [LUMA_W-1:0]       LV = luma_level(g);
		localparam logic signed [CHR_W-1:0] CV = chroma_level(g);
		assign luma_tab[g]   = LV;
		assign chroma_tab[g] = CV;
	end

	logic       active_q;
	logic [1:0] n_q;
	logic [1:0] last_n_q;
	logic [1:0] sh_q;
	logic [9:0] col_q;
	logic [3:0] le_q;
	logic [3:0] lo_q;
	logic [3:0] u_q;
	logic [3:0] v_q;

	logic       accept;
	logic       at_last;
	logic [1:0] last_n;
	logic [1:0] sh;
	logic [4:0] u_sum;
	logic [4:0] v_sum;

	assign at_last = (n_q == last_n_q);
	assign busy    = active_q && !at_last;
	assign accept  = start && !busy;
	assign u_sum   = 5'(u_even) + 5'(u_odd);
	assign v_sum   = 5'(v_even) + 5'(v_odd);

	always_comb begin
		case (cfg.samples_mode)
			SPP_ONE: begin
				last_n = 2'd0;
				sh     = 2'd0;
			end
			SPP_TWO: begin
				last_n = 2'd1;
				sh     = 2'd1;
			end
			default: begin
				last_n = 2'd3;
				sh     = 2'd2;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			n_q      <= 2'd0;
		end else if (accept) begin
			active_q <= 1'b1;
			n_q      <= 2'd0;
		end else if (active_q) begin
			if (at_last)
				active_q <= 1'b0;
			else
				n_q <= n_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_n_q <= last_n;
			sh_q     <= sh;
			col_q    <= pixel_column;
			le_q     <= luma_even;
			lo_q     <= luma_odd;
			u_q      <= cfg.chroma_mix ? u_sum[4:1] : u_even;
			v_q      <= cfg.chroma_mix ? v_sum[4:1] : v_even;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s1.valid <= 1'b0;
		end else begin
			smp_s1.valid <= active_q;
			smp_s1.last  <= at_last;
			smp_s1.ye    <= luma_tab[le_q];
			smp_s1.yo    <= luma_tab[lo_q];
			smp_s1.ul    <= chroma_tab[u_q];
			smp_s1.vl    <= chroma_tab[v_q];
			sum_s1       <= SUM_W'(cfg.horizontal_start) + (SUM_W'(col_q) << sh_q)
				+ SUM_W'(n_q);
		end
	end

endmodule

// ----- rtl/core/pcle_pos.sv -----
`timescale 1ns / 1ps

module pcle_pos #(
	parameter int LINE_SAMPLES = 854
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pcle_pkg::smp_t             smp_s1,
	input  logic [pcle_pkg::SUM_W-1:0] sum_s1,
	output pcle_pkg::smp_t             smp_s3,
	output logic [pcle_pkg::POS_W-1:0] pos_s3
);
	import pcle_pkg::*;

	// position mod line length: floor reciprocal, then one correction
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP       = (1 << RECIP_SHIFT) / LINE_SAMPLES;
	localparam int RW          = $clog2(RECIP + 1);
	localparam int PW          = SUM_W + RW;
	localparam int QW          = PW - RECIP_SHIFT;
	localparam int LW          = $clog2(LINE_SAMPLES + 1);

	smp_t              smp_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic [QW-1:0]     q_s2;
	logic [PW-1:0]     prod;
	logic [QW+LW-1:0]  ql;
	logic [SUM_W-1:0]  rem;
	logic [SUM_W-1:0]  rem_fix;

	assign prod    = PW'(sum_s1) * PW'(RECIP);
	assign ql      = (QW+LW)'(q_s2) * (QW+LW)'(LINE_SAMPLES);
	assign rem     = sum_s2 - SUM_W'(ql);
	assign rem_fix = (rem >= SUM_W'(LINE_SAMPLES)) ? rem - SUM_W'(LINE_SAMPLES) : rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s2.valid <= 1'b0;
			smp_s3.valid <= 1'b0;
		end else begin
			smp_s2.valid <= smp_s1.valid;
			smp_s3.valid <= smp_s2.valid;
			smp_s2.last  <= smp_s1.last;
			smp_s2.ye    <= smp_s1.ye;
			smp_s2.yo    <= smp_s1.yo;
			smp_s2.ul    <= smp_s1.ul;
			smp_s2.vl    <= smp_s1.vl;
			sum_s2       <= sum_s1;
			q_s2         <= prod[PW-1:RECIP_SHIFT];
			smp_s3.last  <= smp_s2.last;
			smp_s3.ye    <= smp_s2.ye;
			smp_s3.yo    <= smp_s2.yo;
			smp_s3.ul    <= smp_s2.ul;
			smp_s3.vl    <= smp_s2.vl;
			pos_s3       <= POS_W'(rem_fix);
		end
	end

endmodule

// ----- rtl/core/pcle_phase.sv -----
`timescale 1ns / 1ps

module pcle_phase #(
	parameter int LINE_SAMPLES   = 854,
	parameter int SINE_ROM_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pcle_pkg::smp_t                    smp_s3,
	input  logic [pcle_pkg::POS_W-1:0]        pos_s3,
	output pcle_pkg::smp_t                    smp_s5,
	output logic [pcle_pkg::POS_W-1:0]        pos_s5,
	output logic signed [pcle_pkg::ROM_W-1:0] sin_s5,
	output logic signed [pcle_pkg::ROM_W-1:0] cos_s5
);
	import pcle_pkg::*;

	localparam int IW  = $clog2(SINE_ROM_DEPTH);
	localparam int PIW = $clog2(LINE_SAMPLES);

	function automatic logic [IW-1:0] idx_of(input int p);
		logic [63:0] c;
		logic [63:0] num;
		c   = 64'(p) + CLOCK_DEN - BURST_ORIGIN;
		num = c * CARRIER_NUM * 64'(SINE_ROM_DEPTH) + CLOCK_DEN / 64'd2;
		return IW'((num / CLOCK_DEN) % SINE_ROM_DEPTH);
	endfunction

	function automatic logic [31:0] turn_of(input int i);
		logic [63:0] w;
		w = (64'(i) << 32) / SINE_ROM_DEPTH;
		return w[31:0];
	endfunction

	logic [IW-1:0]           idx_tab [LINE_SAMPLES];
	logic signed [ROM_W-1:0] sin_tab [SINE_ROM_DEPTH];
	logic signed [ROM_W-1:0] cos_tab [SINE_ROM_DEPTH];

	for (genvar g = 0; g < LINE_SAMPLES; g++) begin : g_idx
		localparam logic [IW-1:0] IV = idx_of(g);
		assign idx_tab[g] = IV;
	end

	for (genvar g = 0; g < SINE_ROM_DEPTH; g++) begin : g_rom
		localparam logic [31:0]             TURN = turn_of(g);
		localparam logic signed [ROM_W-1:0] SV   = rom_entry(TURN, U_GAIN);
		localparam logic signed [ROM_W-1:0] CV   = rom_entry(TURN + QUARTER_TURN, V_GAIN);
		assign sin_tab[g] = SV;
		assign cos_tab[g] = CV;
	end

	smp_t          smp_s4;
	logic [POS_W-1:0] pos_s4;
	logic [IW-1:0] idx_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s4.valid <= 1'b0;
			smp_s5.valid <= 1'b0;
		end else begin
			smp_s4.valid <= smp_s3.valid;
			smp_s5.valid <= smp_s4.valid;
			smp_s4.last  <= smp_s3.last;
			smp_s4.ye    <= smp_s3.ye;
			smp_s4.yo    <= smp_s3.yo;
			smp_s4.ul    <= smp_s3.ul;
			smp_s4.vl    <= smp_s3.vl;
			pos_s4       <= pos_s3;
			idx_s4       <= idx_tab[pos_s3[PIW-1:0]];
			smp_s5.last  <= smp_s4.last;
			smp_s5.ye    <= smp_s4.ye;
			smp_s5.yo    <= smp_s4.yo;
			smp_s5.ul    <= smp_s4.ul;
			smp_s5.vl    <= smp_s4.vl;
			pos_s5       <= pos_s4;
			sin_s5       <= sin_tab[idx_s4];
			cos_s5       <= cos_tab[idx_s4];
		end
	end

endmodule

// ----- rtl/core/pcle_mix.sv -----
`timescale 1ns / 1ps

module pcle_mix (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pcle_pkg::smp_t                    smp_s5,
	input  logic [pcle_pkg::POS_W-1:0]        pos_s5,
	input  logic signed [pcle_pkg::ROM_W-1:0] sin_s5,
	input  logic signed [pcle_pkg::ROM_W-1:0] cos_s5,
	output logic                              strobe,
	output logic [pcle_pkg::POS_W-1:0]        sample_position,
	output logic [pcle_pkg::SMP_W-1:0]        even_line_sample,
	output logic [pcle_pkg::SMP_W-1:0]        odd_line_sample,
	output logic                              last
);
	import pcle_pkg::*;

	localparam int MW = ROM_W + CHR_W;

	logic                 valid_s6;
	logic                 last_s6;
	logic [LUMA_W-1:0]    ye_s6;
	logic [LUMA_W-1:0]    yo_s6;
	logic [POS_W-1:0]     pos_s6;
	logic signed [MW-1:0] uw_s6;
	logic signed [MW-1:0] vw_s6;
	logic [SMP_W-1:0]     uw_x;
	logic [SMP_W-1:0]     vw_x;

	assign uw_x = SMP_W'(uw_s6);
	assign vw_x = SMP_W'(vw_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			valid_s6 <= smp_s5.valid;
			strobe   <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		last_s6          <= smp_s5.last;
		ye_s6            <= smp_s5.ye;
		yo_s6            <= smp_s5.yo;
		pos_s6           <= pos_s5;
		uw_s6            <= MW'(sin_s5) * MW'($signed(smp_s5.ul));
		vw_s6            <= MW'(cos_s5) * MW'($signed(smp_s5.vl));
		last             <= last_s6;
		sample_position  <= pos_s6;
		even_line_sample <= SMP_W'(ye_s6) + uw_x + vw_x;
		odd_line_sample  <= SMP_W'(yo_s6) + uw_x - vw_x;
	end

endmodule

// ----- rtl/core/pal_composite_chroma_luma_encoder.sv -----
`timescale 1ns / 1ps

// PAL composite chroma/luma sample encoder.
// Input: a pixel column word (Y, U, V codes for an even and an odd line) is
// taken at a clock edge where start is high and busy is low.
// Output: 1, 2 or 4 sample words per pixel (samples_mode), one per cycle, each
// shown for one cycle with strobe high; last marks the final sample of a pixel.
// The first sample of a pixel passes the sequencer, the stage registers s1 to s6
// and the output registers; its further samples follow on consecutive cycles.
// The sample sequencer at the input issues one sample into the pipeline per
// cycle, with all samples of a pixel back to back.
// busy is high while the sequencer still has samples of the current pixel to
// issue beyond the present cycle, so a new pixel may enter on the last one.
// Configuration: cfg_write with cfg_index/cfg_data writes one register
// immediately; write only while no pixel is in flight.
// Reset: arst_n clears the pipeline valid bits and loads the register defaults
// (two samples per pixel, start position 256, chroma mixing on).
// The receiver cannot stall; sample words are never held or repeated.
module pal_composite_chroma_luma_encoder #(
	parameter int LINE_SAMPLES   = 854,
	parameter int SINE_ROM_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [1:0]                 cfg_index,
	input  logic [9:0]                 cfg_data,
	input  logic                       start,
	output logic                       busy,
	input  logic [9:0]                 pixel_column,
	input  logic [3:0]                 luma_even,
	input  logic [3:0]                 luma_odd,
	input  logic [3:0]                 u_even,
	input  logic [3:0]                 u_odd,
	input  logic [3:0]                 v_even,
	input  logic [3:0]                 v_odd,
	output logic                       strobe,
	output logic [pcle_pkg::POS_W-1:0] sample_position,
	output logic [pcle_pkg::SMP_W-1:0] even_line_sample,
	output logic [pcle_pkg::SMP_W-1:0] odd_line_sample,
	output logic                       last
);
	import pcle_pkg::*;

	logic [1:0] samples_mode_q;
	logic [9:0] horizontal_start_q;
	logic       chroma_mix_q;
	cfg_t       cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_mode_q     <= SPP_TWO;
			horizontal_start_q <= 10'd256;
			chroma_mix_q       <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_SAMPLES_MODE: samples_mode_q     <= cfg_data[1:0];
				CFG_HSTART:       horizontal_start_q <= cfg_data;
				CFG_CHROMA_MIX:   chroma_mix_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.samples_mode     = samples_mode_q;
	assign cfg.horizontal_start = horizontal_start_q;
	assign cfg.chroma_mix       = chroma_mix_q;

	smp_t                    smp_s1;
	smp_t                    smp_s3;
	smp_t                    smp_s5;
	logic [SUM_W-1:0]        sum_s1;
	logic [POS_W-1:0]        pos_s3;
	logic [POS_W-1:0]        pos_s5;
	logic signed [ROM_W-1:0] sin_s5;
	logic signed [ROM_W-1:0] cos_s5;

	pcle_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.start        (start),
		.busy         (busy),
		.pixel_column (pixel_column),
		.luma_even    (luma_even),
		.luma_odd     (luma_odd),
		.u_even       (u_even),
		.u_odd        (u_odd),
		.v_even       (v_even),
		.v_odd        (v_odd),
		.smp_s1       (smp_s1),
		.sum_s1       (sum_s1)
	);

	pcle_pos #(
		.LINE_SAMPLES (LINE_SAMPLES)
	) u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.smp_s1 (smp_s1),
		.sum_s1 (sum_s1),
		.smp_s3 (smp_s3),
		.pos_s3 (pos_s3)
	);

	pcle_phase #(
		.LINE_SAMPLES   (LINE_SAMPLES),
		.SINE_ROM_DEPTH (SINE_ROM_DEPTH)
	) u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.smp_s3 (smp_s3),
		.pos_s3 (pos_s3),
		.smp_s5 (smp_s5),
		.pos_s5 (pos_s5),
		.sin_s5 (sin_s5),
		.cos_s5 (cos_s5)
	);

	pcle_mix u_mix (
		.clk              (clk),
		.arst_n           (arst_n),
		.smp_s5           (smp_s5),
		.pos_s5           (pos_s5),
		.sin_s5           (sin_s5),
		.cos_s5           (cos_s5),
		.strobe           (strobe),
		.sample_position  (sample_position),
		.even_line_sample (even_line_sample),
		.odd_line_sample  (odd_line_sample),
		.last             (last)
	);

endmodule
